[hdl/cem_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and a helper function for the context error modeler.
// No dependencies.
package cem_pkg;

	localparam int NumCtx = 365;
	localparam int CtxW = 9;
	localparam logic [CtxW-1:0] CtxLast = 9'd364;

	// configuration register indexes
	localparam logic [1:0] REG_T1 = 2'd0;
	localparam logic [1:0] REG_T2 = 2'd1;
	localparam logic [1:0] REG_T3 = 2'd2;
	localparam logic [1:0] REG_HALVE = 2'd3;

	typedef struct packed {
		logic [15:0]       a;
		logic signed [8:0] b;
		logic signed [7:0] c;
		logic [7:0]        n;
	} ctx_entry_t;

	typedef struct packed {
		logic            neg;
		logic [CtxW-1:0] ctx;
		logic [7:0]      px;
	} front_t;

	localparam ctx_entry_t EntryInit = '{a: 16'd4, b: 9'sd0, c: 8'sd0, n: 8'd1};

	// quantize one gradient against the threshold cascade
	function automatic logic signed [3:0] quant(input logic signed [8:0] d,
			input logic [7:0] t1, input logic [7:0] t2, input logic [7:0] t3);
		logic signed [9:0] dw;
		logic signed [9:0] p1;
		logic signed [9:0] p2;
		logic signed [9:0] p3;
		logic signed [3:0] q;
		dw = {d[8], d};
		p1 = signed'({2'b00, t1});
		p2 = signed'({2'b00, t2});
		p3 = signed'({2'b00, t3});
		if (dw <= -p3) q = -4'sd4;
		else if (dw <= -p2) q = -4'sd3;
		else if (dw <= -p1) q = -4'sd2;
		else if (dw < 10'sd0) q = -4'sd1;
		else if (dw == 10'sd0) q = 4'sd0;
		else if (dw < p1) q = 4'sd1;
		else if (dw < p2) q = 4'sd2;
		else if (dw < p3) q = 4'sd3;
		else q = 4'sd4;
		return q;
	endfunction

endpackage

[hdl/cem_ctx_ram.sv]
`timescale 1ns / 1ps
// Context statistics memory: one write port, one registered read port.
// Depends on cem_pkg.
module cem_ctx_ram
	import cem_pkg::*;
(
	input  logic            clk,
	input  logic            we,
	input  logic [CtxW-1:0] waddr,
	input  ctx_entry_t      wdata,
	input  logic            re,
	input  logic [CtxW-1:0] raddr,
	output ctx_entry_t      rdata
);

	ctx_entry_t mem_q [NumCtx];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[hdl/cem_front.sv]
`timescale 1ns / 1ps
// Gradient quantization, context formation and median edge prediction.
// Depends on cem_pkg.
module cem_front
	import cem_pkg::*;
(
	input  logic [7:0] ra,
	input  logic [7:0] rb,
	input  logic [7:0] rc,
	input  logic [7:0] rd,
	input  logic [7:0] t1,
	input  logic [7:0] t2,
	input  logic [7:0] t3,
	output front_t     res
);

	logic signed [3:0]  q0, q1, q2;
	logic signed [3:0]  f0, f1, f2;
	logic signed [10:0] e0, e1, e2, cw;
	logic               neg;
	logic [7:0]         mx, mn;
	logic [8:0]         pw;
	logic [7:0]         px;

	// quantize the three gradients
	always_comb begin
		q0 = quant(signed'({1'b0, rd}) - signed'({1'b0, rb}), t1, t2, t3);
		q1 = quant(signed'({1'b0, rb}) - signed'({1'b0, rc}), t1, t2, t3);
		q2 = quant(signed'({1'b0, rc}) - signed'({1'b0, ra}), t1, t2, t3);
	end

	// fold the sign and form the context index
	always_comb begin
		neg = (q0 < 4'sd0) || ((q0 == 4'sd0) &&
			((q1 < 4'sd0) || ((q1 == 4'sd0) && (q2 < 4'sd0))));
		f0 = neg ? -q0 : q0;
		f1 = neg ? -q1 : q1;
		f2 = neg ? -q2 : q2;
		e0 = 11'(f0);
		e1 = 11'(f1);
		e2 = 11'(f2);
		cw = e0 * 11'sd81 + e1 * 11'sd9 + e2;
		res.neg = neg;
		if (cw < 11'sd0) res.ctx = '0;
		else if (cw > signed'({2'b00, CtxLast})) res.ctx = CtxLast;
		else res.ctx = cw[CtxW-1:0];
		res.px = px;
	end

	// median edge predictor
	always_comb begin
		mx = (ra > rb) ? ra : rb;
		mn = (ra > rb) ? rb : ra;
		pw = {1'b0, ra} + {1'b0, rb} - {1'b0, rc};
		if (rc >= mx) px = mn;
		else if (rc <= mn) px = mx;
		else px = pw[7:0];
	end

endmodule

[hdl/cem_update.sv]
`timescale 1ns / 1ps
// Bias correction, residual mapping, Golomb order and context update.
// Depends on cem_pkg.
module cem_update
	import cem_pkg::*;
(
	input  front_t     fr,
	input  logic [7:0] ix,
	input  ctx_entry_t cur,
	input  logic [7:0] halve_at,
	output logic [7:0] merr,
	output logic [4:0] k,
	output ctx_entry_t nxt
);

	logic signed [10:0] pw;
	logic [7:0]         pxc;
	logic signed [9:0]  ew;
	logic signed [7:0]  err;
	logic signed [9:0]  errw, bw, nw, m;
	logic [16:0]        ge;
	logic [7:0]         amag;
	logic [16:0]        a2;
	logic [15:0]        a2s, a3;
	logic signed [10:0] b2, b3, b4, nn;
	logic [8:0]         n3;
	logic               halve;
	logic signed [7:0]  c2;

	// corrected, clamped prediction and the residual modulo 256
	always_comb begin
		pw = fr.neg ? signed'({3'b000, fr.px}) - 11'(cur.c)
			: signed'({3'b000, fr.px}) + 11'(cur.c);
		if (pw > 11'sd255) pxc = 8'd255;
		else if (pw < 11'sd0) pxc = 8'd0;
		else pxc = pw[7:0];
		ew = signed'({2'b00, ix}) - signed'({2'b00, pxc});
		if (fr.neg) ew = -ew;
		err = signed'(ew[7:0]);
	end

	// Golomb order: smallest k with N shifted left by k reaching A
	always_comb begin
		for (int i = 0; i <= 16; i++) begin
			ge[i] = (({16'd0, cur.n} << i) >= {8'd0, cur.a});
		end
		k = 5'd16;
		for (int i = 16; i >= 0; i--) begin
			if (ge[i]) k = 5'(i);
		end
	end

	// map the residual to a non-negative code
	always_comb begin
		errw = 10'(err);
		bw = 10'(cur.b);
		nw = signed'({2'b00, cur.n});
		if ((k == 5'd0) && ((bw + bw) <= -nw)) begin
			m = (err >= 8'sd0) ? (errw + errw + 10'sd1) : -(errw + errw + 10'sd2);
		end else begin
			m = (err >= 8'sd0) ? (errw + errw) : (-(errw + errw) - 10'sd1);
		end
		merr = m[7:0];
	end

	// update A, B, C and N with halving
	always_comb begin
		amag = (err < 8'sd0) ? 8'(-errw) : 8'(errw);
		a2 = {1'b0, cur.a} + {9'd0, amag};
		a2s = a2[16] ? 16'hFFFF : a2[15:0];
		b2 = 11'(cur.b) + 11'(err);
		halve = (cur.n >= halve_at);
		a3 = halve ? (a2s >> 1) : a2s;
		b3 = halve ? (b2 >>> 1) : b2;
		n3 = (halve ? {2'b00, cur.n[7:1]} : {1'b0, cur.n}) + 9'd1;
		nn = signed'({2'b00, n3});
		c2 = cur.c;
		b4 = b3;
		if (b3 <= -nn) begin
			b4 = b3 + nn;
			if (cur.c > -8'sd128) c2 = cur.c - 8'sd1;
			if (b4 <= -nn) b4 = 11'sd1 - nn;
		end else if (b3 > 11'sd0) begin
			b4 = b3 - nn;
			if (cur.c < 8'sd127) c2 = cur.c + 8'sd1;
			if (b4 > 11'sd0) b4 = 11'sd0;
		end
		nxt.a = a3;
		nxt.b = b4[8:0];
		nxt.c = c2;
		nxt.n = n3[7:0];
	end

endmodule

[hdl/context_error_modeler.sv]
`timescale 1ns / 1ps
// Context error modeler top level: regular-mode context modeling of 8-bit pixels.
// Depends on cem_pkg, cem_front, cem_update and cem_ctx_ram.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one pixel and its four causal
//   neighbours. Output channel (out_valid/out_ready) returns the mapped error,
//   the Golomb order and the context number for that pixel. The user must
//   write the configuration registers (cfg_we/cfg_index/cfg_data, index
//   0..3: thresholds low/mid/high, halving count) only while idle, unenforced.
// Path: the input registers hold the pixel, its context entry is read through
//   the registered read port, and the result is registered as the entry is
//   written back; in_ready stays low until that write-back, one pixel at a time.
// Reset: arst_n clears control state and the configuration registers to
//   their defaults, then a clearing pass writes all 365 context entries,
//   one a cycle; in_ready stays low during the pass.
// Stall: a result waits in the output register; the next pixel is still
//   transferred and processed up to its write-back, which waits for the
//   output register to free.
module context_error_modeler
	import cem_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] sample_now,
	input  logic [7:0] left_neighbour,
	input  logic [7:0] upper_neighbour,
	input  logic [7:0] upper_left_neighbour,
	input  logic [7:0] upper_right_neighbour,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] mapped_error,
	output logic [4:0] golomb_order,
	output logic [8:0] context_number
);

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_READ  = 2'd2;
	localparam logic [1:0] ST_UPD   = 2'd3;

	logic [1:0]      state_q;
	logic [CtxW-1:0] clr_q;
	logic [7:0]      t1_q, t2_q, t3_q, halve_q;
	logic [7:0]      ix_q, ra_q, rb_q, rc_q, rd_q;
	logic [7:0]      ix_s2;
	front_t          fr, fr_s2;
	ctx_entry_t      rdata, nxt, wdata;
	logic [7:0]      merr;
	logic [4:0]      k;
	logic            out_valid_q;
	logic [7:0]      merr_q;
	logic [4:0]      k_q;
	logic [CtxW-1:0] ctx_q;
	logic            commit;
	logic            mem_we;
	logic [CtxW-1:0] waddr;

	assign in_ready = (state_q == ST_IDLE);
	assign commit = (state_q == ST_UPD) && (!out_valid_q || out_ready);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t1_q <= 8'd3;
			t2_q <= 8'd7;
			t3_q <= 8'd21;
			halve_q <= 8'd64;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_T1: t1_q <= cfg_data;
				REG_T2: t2_q <= cfg_data;
				REG_T3: t3_q <= cfg_data;
				REG_HALVE: halve_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer: clear pass, then accept, read, update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CtxLast) state_q <= ST_IDLE;
				end
				ST_IDLE: if (in_valid) state_q <= ST_READ;
				ST_READ: state_q <= ST_UPD;
				ST_UPD: if (commit) state_q <= ST_IDLE;
				default: state_q <= ST_CLEAR;
			endcase
		end
	end

	// hold the transferred pixel
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			ix_q <= sample_now;
			ra_q <= left_neighbour;
			rb_q <= upper_neighbour;
			rc_q <= upper_left_neighbour;
			rd_q <= upper_right_neighbour;
		end
	end

	cem_front u_front (
		.ra(ra_q), .rb(rb_q), .rc(rc_q), .rd(rd_q),
		.t1(t1_q), .t2(t2_q), .t3(t3_q),
		.res(fr)
	);

	// carry the front results alongside the memory read
	always_ff @(posedge clk) begin
		if (state_q == ST_READ) begin
			fr_s2 <= fr;
			ix_s2 <= ix_q;
		end
	end

	assign mem_we = (state_q == ST_CLEAR) || commit;
	assign waddr = (state_q == ST_CLEAR) ? clr_q : fr_s2.ctx;
	assign wdata = (state_q == ST_CLEAR) ? EntryInit : nxt;

	cem_ctx_ram u_ram (
		.clk(clk),
		.we(mem_we), .waddr(waddr), .wdata(wdata),
		.re(state_q == ST_READ), .raddr(fr.ctx), .rdata(rdata)
	);

	cem_update u_update (
		.fr(fr_s2), .ix(ix_s2), .cur(rdata), .halve_at(halve_q),
		.merr(merr), .k(k), .nxt(nxt)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			merr_q <= merr;
			k_q <= k;
			ctx_q <= fr_s2.ctx;
		end
	end

	assign out_valid = out_valid_q;
	assign mapped_error = merr_q;
	assign golomb_order = k_q;
	assign context_number = ctx_q;

endmodule

[hdl/cem_checker.sv]
`timescale 1ns / 1ps
// Port-level checks for the context error modeler, bound to the top level.
// Depends on context_error_modeler.
module cem_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] mapped_error,
	input logic [4:0] golomb_order,
	input logic [8:0] context_number
);

	// hold a stalled result
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(mapped_error) && $stable(golomb_order)
			&& $stable(context_number))
		else $error("stalled result changed");

	// one pixel in flight: no transfer right after a transfer
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while a pixel is in flight");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> context_number <= 9'd364)
		else $error("context number out of range");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> golomb_order <= 5'd16)
		else $error("Golomb order out of range");

endmodule

bind context_error_modeler cem_checker u_cem_checker (
	.clk(clk), .arst_n(arst_n),
	.in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready),
	.mapped_error(mapped_error), .golomb_order(golomb_order),
	.context_number(context_number)
);

[verif/context_error_modeler_checker.sv]
`timescale 1ns / 1ps
// Checker for the context error modeler: predicts each result from the input
// transfers and compares it with the output transfers. Depends on cem_pkg.
module context_error_modeler_checker
	import cem_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [7:0] sample_now,
	input  logic [7:0] left_neighbour,
	input  logic [7:0] upper_neighbour,
	input  logic [7:0] upper_left_neighbour,
	input  logic [7:0] upper_right_neighbour,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic [7:0] mapped_error,
	input  logic [4:0] golomb_order,
	input  logic [8:0] context_number,
	output int         fail_count,
	output int         pending_count,
	output int         result_count
);

	typedef struct packed {
		logic [7:0] merr;
		logic [4:0] k;
		logic [8:0] ctx;
	} pixel_code_t;

	pixel_code_t code_queue[$];

	logic [7:0] thr_low, thr_mid, thr_high, halve_at;
	int sum_abs[NumCtx];
	int sum_bias[NumCtx];
	int corr[NumCtx];
	int occ[NumCtx];

	function automatic int grad_level(input int d);
		if (d <= -int'(thr_high)) return -4;
		if (d <= -int'(thr_mid)) return -3;
		if (d <= -int'(thr_low)) return -2;
		if (d < 0) return -1;
		if (d == 0) return 0;
		if (d < int'(thr_low)) return 1;
		if (d < int'(thr_mid)) return 2;
		if (d < int'(thr_high)) return 3;
		return 4;
	endfunction

	// work out one pixel's code and advance its context
	task automatic code_pixel(input int ix, input int ra, input int rb,
			input int rc, input int rd);
		int q0, q1, q2, cx, px, err, merr, k, b, n, a;
		bit neg;
		pixel_code_t res;
		q0 = grad_level(rd - rb);
		q1 = grad_level(rb - rc);
		q2 = grad_level(rc - ra);
		neg = (q0 < 0) || (q0 == 0 && (q1 < 0 || (q1 == 0 && q2 < 0)));
		if (neg) begin
			q0 = -q0; q1 = -q1; q2 = -q2;
		end
		cx = 81 * q0 + 9 * q1 + q2;
		if (cx < 0) cx = 0;
		if (cx > NumCtx - 1) cx = NumCtx - 1;
		if (rc >= ((ra > rb) ? ra : rb)) px = (ra < rb) ? ra : rb;
		else if (rc <= ((ra < rb) ? ra : rb)) px = (ra > rb) ? ra : rb;
		else px = ra + rb - rc;
		px = neg ? px - corr[cx] : px + corr[cx];
		if (px > 255) px = 255;
		else if (px < 0) px = 0;
		err = ix - px;
		if (neg) err = -err;
		if (err < 0) err += 256;
		if (err >= 128) err -= 256;
		a = sum_abs[cx];
		n = occ[cx];
		k = 0;
		while (k < 16 && (n << k) < a) k++;
		b = sum_bias[cx];
		if (k == 0 && 2 * b <= -n) merr = (err >= 0) ? 2 * err + 1 : -2 * (err + 1);
		else merr = (err >= 0) ? 2 * err : -2 * err - 1;
		b += err;
		a += (err < 0) ? -err : err;
		if (a > 65535) a = 65535;
		if (n >= int'(halve_at)) begin
			a = a >> 1;
			b = (b >= 0) ? b / 2 : -((1 - b) / 2);
			n = n >> 1;
		end
		n += 1;
		if (b <= -n) begin
			b += n;
			if (corr[cx] > -128) corr[cx]--;
			if (b <= -n) b = -n + 1;
		end else if (b > 0) begin
			b -= n;
			if (corr[cx] < 127) corr[cx]++;
			if (b > 0) b = 0;
		end
		sum_abs[cx] = a;
		sum_bias[cx] = b;
		occ[cx] = n & 255;
		res.merr = merr[7:0];
		res.k = k[4:0];
		res.ctx = cx[8:0];
		code_queue.push_back(res);
	endtask

	assign pending_count = code_queue.size();

	// track configuration, predict on input transfers, compare on output transfers
	always @(posedge clk or negedge arst_n) begin
		pixel_code_t want;
		if (!arst_n) begin
			thr_low <= 8'd3;
			thr_mid <= 8'd7;
			thr_high <= 8'd21;
			halve_at <= 8'd64;
			for (int i = 0; i < NumCtx; i++) begin
				sum_abs[i] = 4; sum_bias[i] = 0; corr[i] = 0; occ[i] = 1;
			end
			code_queue.delete();
			fail_count <= 0;
			result_count <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_T1: thr_low <= cfg_data;
					REG_T2: thr_mid <= cfg_data;
					REG_T3: thr_high <= cfg_data;
					REG_HALVE: halve_at <= cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				code_pixel(sample_now, left_neighbour, upper_neighbour,
					upper_left_neighbour, upper_right_neighbour);
			if (out_valid && out_ready) begin
				result_count <= result_count + 1;
				if (code_queue.size() == 0) begin
					if (fail_count < 10)
						$display("checker: result with nothing expected ctx=%0d", context_number);
					fail_count <= fail_count + 1;
				end else begin
					want = code_queue.pop_front();
					if (want.merr !== mapped_error || want.k !== golomb_order
							|| want.ctx !== context_number) begin
						if (fail_count < 10)
							$display("checker: mismatch exp merr=%0d k=%0d ctx=%0d got merr=%0d k=%0d ctx=%0d",
								want.merr, want.k, want.ctx, mapped_error, golomb_order,
								context_number);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

endmodule

[verif/context_error_modeler_tb.sv]
`timescale 1ns / 1ps
// Testbench top for the context error modeler: drives pixels, configuration
// and output stalls, and gives the verdict. Depends on the modeler, its checker and cem_pkg.
module context_error_modeler_tb;
	import cem_pkg::*;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [1:0] cfg_index;
	logic [7:0] cfg_data;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] sample_now, left_neighbour, upper_neighbour;
	logic [7:0] upper_left_neighbour, upper_right_neighbour;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] mapped_error;
	logic [4:0] golomb_order;
	logic [8:0] context_number;
	int         fail_count, pending_count, result_count;
	int         idle_cycles;
	int         pixel_total;
	bit         stall_pause;

	context_error_modeler DUT (.*);
	context_error_modeler_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	// push one pixel through the input channel; valid stays high into the next
	// pixel when no gap follows
	task automatic send_pixel(input logic [7:0] ix, input logic [7:0] ra,
			input logic [7:0] rb, input logic [7:0] rc, input logic [7:0] rd,
			input bit gaps);
		int g;
		g = gaps ? gap_len() : 0;
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample_now <= ix;
		left_neighbour <= ra;
		upper_neighbour <= rb;
		upper_left_neighbour <= rc;
		upper_right_neighbour <= rd;
		@(negedge clk);
		while (!in_ready) @(negedge clk);
		@(posedge clk);
		pixel_total++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_count != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// textured pixel: neighbours close to a base, with occasional edges
	task automatic random_pixel(input bit gaps);
		int base, spread;
		logic [7:0] v[5];
		base = $urandom_range(0, 255);
		spread = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 12) : 255;
		for (int i = 0; i < 5; i++) begin
			int x;
			x = base + $urandom_range(0, 2 * spread) - spread;
			if (x < 0) x = 0;
			if (x > 255) x = 255;
			v[i] = x[7:0];
		end
		if ($urandom_range(0, 19) == 0) v[0] = 8'($urandom());
		send_pixel(v[0], v[1], v[2], v[3], v[4], gaps);
	endtask

	// output stalls, held off during the flat-out stretches
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (stall_pause) begin
			out_ready <= 1'b1;
		end else begin
			out_ready <= ($urandom_range(0, 99) < 65) ||
				($urandom_range(0, 99) < 3 ? 1'b0 : out_ready);
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 5000) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		logic [7:0] ext[4];
		ext = '{8'd0, 8'd255, 8'd128, 8'd127};
		pixel_total = 0;
		stall_pause = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
		in_valid = 1'b0;
		sample_now = '0; left_neighbour = '0; upper_neighbour = '0;
		upper_left_neighbour = '0; upper_right_neighbour = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, flat areas, sharp edges on every gradient
		send_pixel(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 0);
		send_pixel(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 0);
		send_pixel(8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 0);
		send_pixel(8'd0, 8'd255, 8'd255, 8'd255, 8'd255, 0);
		for (int i = 0; i < 4; i++)
			for (int j = 0; j < 4; j++)
				send_pixel(ext[i], ext[j], ext[(i + j) % 4], ext[(i + 1) % 4], ext[(j + 3) % 4], 0);
		send_pixel(8'd10, 8'd200, 8'd50, 8'd255, 8'd0, 0);
		send_pixel(8'd128, 8'd50, 8'd200, 8'd0, 8'd255, 0);
		drain();

		// several threshold and halving settings, extremes included
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: begin write_reg(REG_T1, 8'd1); write_reg(REG_T2, 8'd1);
					write_reg(REG_T3, 8'd1); write_reg(REG_HALVE, 8'd2); end
				1: begin write_reg(REG_T1, 8'd255); write_reg(REG_T2, 8'd255);
					write_reg(REG_T3, 8'd255); write_reg(REG_HALVE, 8'd255); end
				2: begin write_reg(REG_T1, 8'd3); write_reg(REG_T2, 8'd7);
					write_reg(REG_T3, 8'd21); write_reg(REG_HALVE, 8'd64); end
				3: begin write_reg(REG_T1, 8'd20); write_reg(REG_T2, 8'd5);
					write_reg(REG_T3, 8'd2); write_reg(REG_HALVE, 8'd0); end
				4: begin write_reg(REG_T1, 8'($urandom_range(1, 255)));
					write_reg(REG_T2, 8'($urandom_range(1, 255)));
					write_reg(REG_T3, 8'($urandom_range(1, 255)));
					write_reg(REG_HALVE, 8'($urandom_range(1, 255))); end
				default: begin write_reg(REG_T1, 8'd2); write_reg(REG_T2, 8'd6);
					write_reg(REG_T3, 8'd15); write_reg(REG_HALVE, 8'd16); end
			endcase
			stall_pause <= 1'b1;
			for (int i = 0; i < 40; i++) random_pixel(0);
			stall_pause <= 1'b0;
			for (int i = 0; i < 230; i++) random_pixel(1);
			drain();
		end

		$display("tb: %0d pixels coded over six register settings, %0d codes checked",
			pixel_total, result_count);
		if (fail_count == 0 && pending_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

[context_error_modeler.f]
hdl/cem_pkg.sv
hdl/cem_ctx_ram.sv
hdl/cem_front.sv
hdl/cem_update.sv
hdl/context_error_modeler.sv
hdl/cem_checker.sv
verif/context_error_modeler_checker.sv
verif/context_error_modeler_tb.sv
